// ===== sv/sphot_pkg.sv =====
package sphot_pkg;

    typedef enum logic [1:0] {
        OP_ACCESS  = 2'd0,
        OP_DECAY   = 2'd1,
        OP_INSTALL = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    localparam logic [31:0] HASH_MUL = 32'h85ebca6b;

    // datapath commands from the controller
    typedef struct packed {
        logic load;        // capture the request
        logic clear_step;  // write zero at the clear address
        logic act_rd;      // read activity cell of the current row
        logic act_wr;      // write back EMA value, fold min
        logic srch_rd;     // read slot entry at search index
        logic srch_chk;    // compare entry
        logic reu_rd;      // read reuse cell of the current row
        logic reu_wr;      // write back incremented value, fold min
        logic hot_calc;    // compute hotness, write slot
        logic dec_rd;      // read activity cell at sweep index
        logic dec_wr;      // write decayed value
        logic inst_wr;     // install write
        logic out_load;    // capture result
    } ctl_cmd_t;

    typedef struct packed {
        logic row_last;
        logic srch_done;
        logic srch_hit;
        logic sweep_last;
        logic [1:0] in_op;  // opcode of the waiting request
        logic [1:0] op;     // opcode of the captured request
    } ctl_sts_t;

    function automatic logic [31:0] row_hash(input logic [31:0] key, input logic [3:0] row);
        logic [31:0] x;
        logic [31:0] m;
        x = key ^ {row, 28'd0};
        x = x ^ (x >> 16);
        m = x * HASH_MUL;
        m = m ^ (m >> 13);
        return m;
    endfunction

endpackage

// ===== sv/sketch_page_hotness_tracker_unit.sv =====
// channel | dir | tdata fields (low bit up)                              | tuser
// s_axis  | in  | page_id[31:0] tstamp[47:32] slot[55:48]                | opcode[1:0]
// m_axis  | out | hotness[15:0] act_min[23:16] reu_min[31:24] rbin[33:32] | found
// cfg     | in  | slot_limit[8:0]                                        | -
// One request at a time. Access updates each activity row, then searches slots
// below limit = slot_limit saturated to PAGE_SLOTS; a hit updates each reuse row
// and computes hotness. Decay sweeps every activity cell.
// Install and unused opcodes go straight to the result.
// After reset both sketch memories are zeroed, one cell a cycle,
// while s_axis_tready is low.
// A held result stalls the next request; the output register frees when taken.
module sketch_page_hotness_tracker_unit
    import sphot_pkg::*;
#(
    parameter int PAGE_SLOTS   = 256,
    parameter int SKETCH_ROWS  = 4,
    parameter int SKETCH_WIDTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // page_id, tstamp, slot
    input  logic [1:0]  s_axis_tuser,  // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // hotness, act_min, reu_min, rbin
    output logic        m_axis_tuser,  // found
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;
    logic busy, in_fire, out_free;
    logic [8:0] tsize_reg;
    logic ovalid_reg;
    logic [15:0] r_hot;
    logic [7:0] r_act, r_reu;
    logic [1:0] r_bin;
    logic r_found;

    assign s_axis_tready = !busy;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_free = !ovalid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tsize_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we) tsize_reg <= cfg_wdata;
            if (cmd.out_load) ovalid_reg <= 1'b1;
            else if (m_axis_tready) ovalid_reg <= 1'b0;
        end
    end

    sphot_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
        .sts(sts), .busy(busy), .cmd(cmd)
    );

    sphot_dpath #(
        .PAGE_SLOTS(PAGE_SLOTS), .SKETCH_ROWS(SKETCH_ROWS), .SKETCH_WIDTH(SKETCH_WIDTH)
    ) u_dpath (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .in_op(s_axis_tuser), .in_page(s_axis_tdata[31:0]),
        .in_time(s_axis_tdata[47:32]), .in_slot(s_axis_tdata[55:48]),
        .slot_limit(tsize_reg),
        .r_found(r_found), .r_hot(r_hot), .r_act(r_act), .r_reu(r_reu), .r_bin(r_bin)
    );

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = {6'd0, r_bin, r_reu, r_act, r_hot};
    assign m_axis_tuser = r_found;

endmodule

// ===== sv/sphot_ctrl.sv =====
module sphot_ctrl
    import sphot_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_fire,
    input  logic     out_free,
    input  ctl_sts_t sts,
    output logic     busy,
    output ctl_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ACT_RD, S_ACT_WR, S_SRCH_RD, S_SRCH_CHK,
        S_REU_RD, S_REU_WR, S_HOT, S_DEC_RD, S_DEC_WR, S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.sweep_last) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DONE;
                    unique case (sts.in_op)
                        OP_ACCESS:  state_next = S_ACT_RD;
                        OP_DECAY:   state_next = S_DEC_RD;
                        OP_INSTALL: state_next = S_DONE;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_ACT_RD:
            begin
                cmd.act_rd = 1'b1;
                state_next = S_ACT_WR;
            end
            S_ACT_WR:
            begin
                cmd.act_wr = 1'b1;
                state_next = sts.row_last ? S_SRCH_RD : S_ACT_RD;
            end
            S_SRCH_RD:
            begin
                if (sts.srch_done) state_next = S_DONE;
                else
                begin
                    cmd.srch_rd = 1'b1;
                    state_next = S_SRCH_CHK;
                end
            end
            S_SRCH_CHK:
            begin
                cmd.srch_chk = 1'b1;
                state_next = sts.srch_hit ? S_REU_RD : S_SRCH_RD;
            end
            S_REU_RD:
            begin
                cmd.reu_rd = 1'b1;
                state_next = S_REU_WR;
            end
            S_REU_WR:
            begin
                cmd.reu_wr = 1'b1;
                state_next = sts.row_last ? S_HOT : S_REU_RD;
            end
            S_HOT:
            begin
                cmd.hot_calc = 1'b1;
                state_next = S_DONE;
            end
            S_DEC_RD:
            begin
                cmd.dec_rd = 1'b1;
                state_next = S_DEC_WR;
            end
            S_DEC_WR:
            begin
                cmd.dec_wr = 1'b1;
                state_next = sts.sweep_last ? S_DONE : S_DEC_RD;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.inst_wr = (sts.op == OP_INSTALL);
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_CLEAR;
        else state_reg <= state_next;
    end

`ifndef SYNTH
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE) else $error("load outside idle");
    a_one_wr: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.act_wr, cmd.reu_wr, cmd.dec_wr, cmd.clear_step}) <= 1)
        else $error("write conflict");
    a_hit_goes_reuse: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.srch_chk && sts.srch_hit) |=> state_reg == S_REU_RD)
        else $error("hit lost");
`endif

endmodule

// ===== sv/sphot_dpath.sv =====
module sphot_dpath
    import sphot_pkg::*;
#(
    parameter int PAGE_SLOTS   = 256,
    parameter int SKETCH_ROWS  = 4,
    parameter int SKETCH_WIDTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_cmd_t    cmd,
    output ctl_sts_t    sts,
    input  logic [1:0]  in_op,
    input  logic [31:0] in_page,
    input  logic [15:0] in_time,
    input  logic [7:0]  in_slot,
    input  logic [8:0]  slot_limit,
    output logic        r_found,
    output logic [15:0] r_hot,
    output logic [7:0]  r_act,
    output logic [7:0]  r_reu,
    output logic [1:0]  r_bin
);

    localparam int CELLS = SKETCH_ROWS * SKETCH_WIDTH;
    localparam int CW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int RW = (SKETCH_ROWS > 1) ? $clog2(SKETCH_ROWS) : 1;
    localparam int SW = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
    localparam int COLW = (SKETCH_WIDTH > 1) ? $clog2(SKETCH_WIDTH) : 1;

    logic [7:0]  act_mem [CELLS];
    logic [7:0]  reu_mem [CELLS];
    logic [63:0] slot_mem [PAGE_SLOTS];
    logic [PAGE_SLOTS-1:0] valid_reg;

    logic [1:0]  op_reg;
    logic [31:0] page_reg;
    logic [15:0] time_reg;
    logic [7:0]  slot_reg;
    logic [RW:0] row_reg;
    logic [CW:0] sweep_reg;
    logic [SW:0] idx_reg;
    logic [SW:0] limit_reg;
    logic [7:0]  rd_reg;
    logic [63:0] ent_reg;
    logic [CW-1:0] addr_reg;
    logic [7:0]  act_min_reg, reu_min_reg;
    logic [1:0]  bin_reg;
    logic        hit_reg;
    logic [15:0] hot_reg;

    // column of the current row; % by a constant on a 16-bit value
    logic [31:0] key, hsh;
    logic [15:0] col16;
    logic [CW-1:0] cur_addr;
    logic [15:0] rdist;
    logic [1:0]  bin_c;
    logic [8:0]  ema_nv;
    logic [8:0]  reu_nv;
    logic [15:0] prod;
    logic [16:0] anorm;
    logic [8:0]  rnorm;
    logic [25:0] hsum;

    assign key = (op_reg == OP_ACCESS && hit_reg) ? (page_reg ^ {2'b00, bin_reg, 28'd0})
                                                  : page_reg;
    assign hsh = row_hash(key, 4'(row_reg));
    assign col16 = 16'(hsh[15:0] % 16'(SKETCH_WIDTH));
    assign cur_addr = CW'(row_reg[RW-1:0] * SKETCH_WIDTH) + CW'(col16[COLW-1:0]);

    assign rdist = time_reg - ent_reg[47:32];
    assign bin_c = (rdist <= 16'd15) ? 2'd0 : (rdist <= 16'd63) ? 2'd1 :
                   (rdist <= 16'd255) ? 2'd2 : 2'd3;

    assign prod   = rd_reg * 8'd153;
    assign ema_nv = 9'((prod + 16'd26265) >> 8);
    assign reu_nv = (rd_reg == 8'd255) ? 9'd255 : {1'b0, rd_reg} + 9'd1;
    // act*256/255 for act<=255: act + (act==255)
    assign anorm = 17'(act_min_reg) + 17'(act_min_reg == 8'hFF);
    assign rnorm = (bin_reg == 2'd0) ? 9'd256 : (bin_reg == 2'd1) ? 9'd179 :
                   (bin_reg == 2'd2) ? 9'd102 : 9'd25;
    assign hsum = 26'(anorm) * 26'd179 + 26'(rnorm) * 26'd76;

    assign sts.row_last   = (row_reg == (RW+1)'(SKETCH_ROWS - 1));
    assign sts.srch_done  = (idx_reg >= limit_reg);
    assign sts.srch_hit   = valid_reg[idx_reg[SW-1:0]] && ent_reg[31:0] == page_reg;
    assign sts.sweep_last = (sweep_reg == (CW+1)'(CELLS - 1));
    assign sts.in_op      = in_op;
    assign sts.op         = op_reg;

    // memory ports
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            act_mem[sweep_reg[CW-1:0]] <= 8'd0;
            reu_mem[sweep_reg[CW-1:0]] <= 8'd0;
        end
        else if (cmd.act_wr) act_mem[addr_reg] <= ema_nv[7:0];
        else if (cmd.dec_wr) act_mem[addr_reg] <= prod[15:8];
        if (cmd.act_rd) rd_reg <= act_mem[cur_addr];
        else if (cmd.dec_rd) rd_reg <= act_mem[sweep_reg[CW-1:0]];
        else if (cmd.reu_rd) rd_reg <= reu_mem[cur_addr];
        if (cmd.reu_wr) reu_mem[addr_reg] <= reu_nv[7:0];
        if (cmd.srch_rd) ent_reg <= slot_mem[idx_reg[SW-1:0]];
        if (cmd.hot_calc)
            slot_mem[idx_reg[SW-1:0]] <= {hsum[23:8], time_reg, page_reg};
        else if (cmd.inst_wr && {24'd0, slot_reg} < 32'(PAGE_SLOTS))
            slot_mem[slot_reg[SW-1:0]] <= {16'd0, time_reg, page_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_op;
            page_reg <= in_page;
            time_reg <= in_time;
            slot_reg <= in_slot;
            limit_reg <= ({23'd0, slot_limit} > 32'(PAGE_SLOTS)) ? (SW+1)'(PAGE_SLOTS)
                                                              : (SW+1)'(slot_limit);
            act_min_reg <= 8'd0;
            reu_min_reg <= 8'd0;
            bin_reg <= 2'd0;
            hot_reg <= 16'd0;
        end
        if (cmd.act_rd || cmd.reu_rd) addr_reg <= cur_addr;
        if (cmd.dec_rd) addr_reg <= sweep_reg[CW-1:0];
        if (cmd.act_wr && (row_reg == '0 || ema_nv[7:0] < act_min_reg))
            act_min_reg <= ema_nv[7:0];
        if (cmd.reu_wr && (row_reg == '0 || reu_nv[7:0] < reu_min_reg))
            reu_min_reg <= reu_nv[7:0];
        if (cmd.srch_chk && sts.srch_hit) bin_reg <= bin_c;
        if (cmd.hot_calc) hot_reg <= hsum[23:8];
        if (cmd.out_load)
        begin
            r_found <= hit_reg;
            r_hot   <= hot_reg;
            r_act   <= act_min_reg;
            r_reu   <= reu_min_reg;
            r_bin   <= bin_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            row_reg   <= '0;
            sweep_reg <= '0;
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                row_reg <= '0;
                sweep_reg <= '0;
                idx_reg <= '0;
                hit_reg <= 1'b0;
            end
            if (cmd.clear_step) sweep_reg <= sweep_reg + 1'b1;
            if (cmd.dec_wr) sweep_reg <= sweep_reg + 1'b1;
            if (cmd.act_wr || cmd.reu_wr)
                row_reg <= sts.row_last ? '0 : row_reg + 1'b1;
            if (cmd.srch_chk)
            begin
                if (sts.srch_hit) hit_reg <= 1'b1;
                else idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.inst_wr && {24'd0, slot_reg} < 32'(PAGE_SLOTS))
                valid_reg[slot_reg[SW-1:0]] <= 1'b1;
        end
    end

`ifndef SYNTH
    a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hot_calc |-> hit_reg && valid_reg[idx_reg[SW-1:0]])
        else $error("hotness on invalid slot");
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.srch_rd |-> idx_reg < limit_reg) else $error("search past limit");
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && !hit_reg) |-> hot_reg == 16'd0 && reu_min_reg == 8'd0)
        else $error("miss carries data");
`endif

endmodule

// ===== tb/tb_sketch_page_hotness_tracker_unit.sv =====
`timescale 1ns / 100ps

module tb_sketch_page_hotness_tracker_unit;
    import sphot_pkg::*;

    localparam int SLOTS = 256;
    localparam int ROWS  = 4;
    localparam int WIDTH = 256;

    typedef struct packed {
        logic       found;
        logic [15:0] hot;
        logic [7:0]  act;
        logic [7:0]  reu;
        logic [1:0]  bin;
    } hot_res_t;

    typedef struct {
        opcode_t     op;
        logic [31:0] page;
        logic [15:0] now;
        logic [7:0]  slot;
        logic        typed;
        hot_res_t    res;
    } req_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_we;
    logic [8:0]  cfg_wdata;

    sketch_page_hotness_tracker_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // shadow state
    logic [7:0]  act_cnt [ROWS*WIDTH];
    logic [7:0]  reu_cnt [ROWS*WIDTH];
    logic        slot_ok [SLOTS];
    logic [31:0] slot_page [SLOTS];
    logic [15:0] slot_last [SLOTS];
    logic [8:0]  tbl_size;
    logic [31:0] used_pages [$];

    hot_res_t pending_res [$];
    int       errors;
    logic     stall_on;

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #400ms;
        $display("FAIL");
        $finish;
    end

    function automatic int sketch_col(logic [31:0] key, int row);
        logic [31:0] x;
        x = key ^ (32'(row) << 28);
        x = x ^ (x >> 16);
        x = x * 32'h85ebca6b;
        x = x ^ (x >> 13);
        return int'(x[15:0]) % WIDTH;
    endfunction

    function automatic hot_res_t track_hotness(opcode_t op, logic [31:0] page,
                                               logic [15:0] now, logic [7:0] slot);
        hot_res_t r;
        int lim, idx, nv, c;
        logic [15:0] rdist;
        logic [31:0] key;
        int anorm, rnorm;
        r = '0;
        if (op == OP_ACCESS)
        begin
            lim = tbl_size > SLOTS ? SLOTS : tbl_size;
            for (int k = 0; k < ROWS; k++)
            begin
                idx = k * WIDTH + sketch_col(page, k);
                nv = (act_cnt[idx] * 153 + 103 * 255) >> 8;
                act_cnt[idx] = nv[7:0];
                if (k == 0 || nv < r.act) r.act = nv[7:0];
            end
            for (int i = 0; i < lim; i++)
            begin
                if (slot_ok[i] && slot_page[i] == page)
                begin
                    rdist = now - slot_last[i];
                    r.bin = rdist <= 15 ? 2'd0 : rdist <= 63 ? 2'd1 :
                            rdist <= 255 ? 2'd2 : 2'd3;
                    key = page ^ (32'(r.bin) << 28);
                    for (int k = 0; k < ROWS; k++)
                    begin
                        idx = k * WIDTH + sketch_col(key, k);
                        c = reu_cnt[idx];
                        if (c < 255) c++;
                        reu_cnt[idx] = c[7:0];
                        if (k == 0 || c < r.reu) r.reu = c[7:0];
                    end
                    anorm = (int'(r.act) * 256) / 255;
                    rnorm = r.bin == 0 ? 256 : r.bin == 1 ? 179 : r.bin == 2 ? 102 : 25;
                    r.hot = 16'((179 * anorm + 76 * rnorm) >> 8);
                    slot_last[i] = now;
                    r.found = 1'b1;
                    break;
                end
            end
        end
        else if (op == OP_DECAY)
        begin
            for (int i = 0; i < ROWS * WIDTH; i++)
                act_cnt[i] = 8'((act_cnt[i] * 153) >> 8);
        end
        else if (op == OP_INSTALL)
        begin
            slot_page[slot] = page;
            slot_last[slot] = now;
            slot_ok[slot] = 1'b1;
        end
        return r;
    endfunction

    task automatic send_request(opcode_t op, logic [31:0] page, logic [15:0] now,
                                logic [7:0] slot, logic typed, hot_res_t want);
        hot_res_t r;
        int gap;
        r = track_hotness(op, page, now, slot);
        if (typed && r != want)
        begin
            $display("%0t table row mismatch: expected %h actual %h", $time, want, r);
            errors++;
        end
        pending_res.push_back(r);
        gap = ($urandom_range(0, 9) < 6) ? 0 :
              ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        // valid stays high across back-to-back requests
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {slot, now, page};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic write_table_size(logic [8:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_res.size() != 0) @(posedge clk);
        // the block is idle once its last result is taken
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tbl_size = v;
    endtask

    // result checker and sink stall
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            hot_res_t got;
            hot_res_t want;
            got = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[23:16],
                   m_axis_tdata[31:24], m_axis_tdata[33:32]};
            if (pending_res.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_res.pop_front();
                if (got.found !== want.found || got.hot !== want.hot || got.act !== want.act
                    || got.reu !== want.reu || got.bin !== want.bin)
                begin
                    $display("%0t mismatch: expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
        if (!stall_on)
            m_axis_tready <= 1'b1;
        else if ($urandom_range(0, 99) < 3)
            m_axis_tready <= ($urandom_range(0, 1) == 1);
        else if (!m_axis_tready && $urandom_range(0, 3) == 0)
            m_axis_tready <= 1'b1;
        else if (m_axis_tready && $urandom_range(0, 4) == 0)
            m_axis_tready <= 1'b0;
    end

    initial
    begin
        req_row_t rows [$];
        req_row_t t;
        hot_res_t zero_res;
        hot_res_t first_res;
        logic [31:0] pg;
        int n, kind, tmo;
        opcode_t op;
        logic [15:0] tnow;
        logic [8:0] sizes [4];

        zero_res = '0;
        first_res = '0;
        first_res.act = 8'd102;
        errors = 0;
        stall_on = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_ACCESS;
        m_axis_tready = 1'b1;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        tbl_size = '0;
        for (int i = 0; i < ROWS * WIDTH; i++)
        begin
            act_cnt[i] = '0;
            reu_cnt[i] = '0;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_ok[i] = 1'b0;
            slot_page[i] = '0;
            slot_last[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed table: access after reset gives activity 102 (103*255>>8)
        rows = '{
            '{OP_ACCESS,  32'h0000_0000, 16'h0000, 8'h00, 1'b1, first_res},
            '{OP_DECAY,   32'h0,         16'h0,    8'h00, 1'b1, zero_res},
            '{OP_NONE,    32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1'b1, zero_res},
            '{OP_INSTALL, 32'hFFFF_FFFF, 16'hFFF0, 8'hFF, 1'b1, zero_res},
            '{OP_INSTALL, 32'h0000_0000, 16'h0000, 8'h00, 1'b1, zero_res},
            '{OP_INSTALL, 32'h1234_5678, 16'h0100, 8'h01, 1'b1, zero_res},
            '{OP_INSTALL, 32'h1234_5678, 16'h0200, 8'h02, 1'b1, zero_res},
            '{OP_INSTALL, 32'hAAAA_5555, 16'h8000, 8'h80, 1'b1, zero_res},
            '{OP_ACCESS,  32'h0000_0000, 16'h0005, 8'h00, 1'b0, zero_res},
            '{OP_ACCESS,  32'h1234_5678, 16'h0130, 8'h00, 1'b0, zero_res},
            '{OP_ACCESS,  32'h1234_5678, 16'h0200, 8'h00, 1'b0, zero_res},
            '{OP_ACCESS,  32'hFFFF_FFFF, 16'h000F, 8'h00, 1'b0, zero_res},
            '{OP_ACCESS,  32'hAAAA_5555, 16'h7FFF, 8'h00, 1'b0, zero_res},
            '{OP_DECAY,   32'h0,         16'h0,    8'h00, 1'b0, zero_res},
            '{OP_ACCESS,  32'h1234_5678, 16'h0241, 8'h7F, 1'b0, zero_res},
            '{OP_ACCESS,  32'h5555_AAAA, 16'h1234, 8'h00, 1'b0, zero_res}
        };
        // table_size 0: no hits for the first row
        send_request(rows[0].op, rows[0].page, rows[0].now, rows[0].slot,
                     rows[0].typed, rows[0].res);
        write_table_size(9'd511);
        for (int i = 1; i < rows.size(); i++)
        begin
            t = rows[i];
            send_request(t.op, t.page, t.now, t.slot, t.typed, t.res);
        end
        write_table_size(9'd256);
        send_request(OP_ACCESS, 32'hFFFF_FFFF, 16'h0010, 8'h00, 1'b0, zero_res);

        sizes = '{9'd256, 9'd16, 9'd1, 9'd200};
        tnow = 16'h0300;
        used_pages = '{32'h0, 32'h1234_5678, 32'hFFFF_FFFF, 32'hAAAA_5555};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_table_size(sizes[ph]);
            stall_on = (ph != 1);
            n = (ph == 0) ? 300 : 440;
            for (int i = 0; i < n; i++)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 70)
                begin
                    op = OP_ACCESS;
                    pg = ($urandom_range(0, 9) < 8) ?
                         used_pages[$urandom_range(0, used_pages.size() - 1)] : $urandom;
                end
                else if (kind < 92)
                begin
                    op = OP_INSTALL;
                    pg = ($urandom_range(0, 3) == 0) ?
                         used_pages[$urandom_range(0, used_pages.size() - 1)] : $urandom;
                    if (used_pages.size() < 64) used_pages.push_back(pg);
                end
                else if (kind < 95)
                begin
                    op = OP_DECAY;
                    pg = $urandom;
                end
                else
                begin
                    op = OP_NONE;
                    pg = $urandom;
                end
                // time mostly advances a little, sometimes jumps far
                tnow = tnow + (($urandom_range(0, 3) == 0) ? 16'($urandom) :
                               16'($urandom_range(0, 300)));
                send_request(op, pg, tnow,
                             (ph == 2 && op == OP_INSTALL && $urandom_range(0, 1) == 0) ?
                             8'h00 : 8'($urandom_range(0, 255)), 1'b0, zero_res);
            end
        end
        s_axis_tvalid <= 1'b0;

        tmo = 0;
        while (pending_res.size() != 0 && tmo < 200000)
        begin
            @(posedge clk);
            tmo++;
        end
        repeat (2200) @(posedge clk);
        if (errors == 0 && pending_res.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
